FILE: rtl/riff_signature_carver_macros.svh
// ----------------------------------------------------------------------------
// riff_signature_carver_macros.svh
// Assertion macros of the carver RTL. All use clk and arst_n.
// ----------------------------------------------------------------------------
`ifndef RIFF_SIGNATURE_CARVER_MACROS_SVH
`define RIFF_SIGNATURE_CARVER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define RSC_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define RSC_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/rsc_pkg.sv
// ----------------------------------------------------------------------------
// rsc_pkg
// Types, constants and the signature table of the RIFF signature carver.
// ----------------------------------------------------------------------------
package rsc_pkg;

	localparam int FILE_COUNT_BITS = 16;

	localparam logic [1:0] PH_SCAN = 2'd0;
	localparam logic [1:0] PH_LEN  = 2'd1;
	localparam logic [1:0] PH_BODY = 2'd2;

	localparam logic [7:0] SIG_R = 8'h52;
	localparam logic [7:0] SIG_I = 8'h49;
	localparam logic [7:0] SIG_F = 8'h46;

	typedef struct packed {
		logic [1:0]                 phase;
		logic [1:0]                 match_pos;
		logic [1:0]                 length_pos;
		logic [31:0]                length_acc;
		logic [31:0]                bytes_left;
		logic [FILE_COUNT_BITS-1:0] file_count;
	} carve_state_t;

	// One word produced by a step; sig_burst means the four signature words.
	typedef struct packed {
		logic        valid;
		logic        sig_burst;
		logic [7:0]  data;
		logic [15:0] number;
		logic        last;
		logic        aborted;
	} carve_res_t;

	function automatic logic [7:0] sig_byte(input logic [1:0] idx);
		logic [7:0] b;
		unique case (idx)
			2'd0:    b = SIG_R;
			2'd1:    b = SIG_I;
			default: b = SIG_F;
		endcase
		return b;
	endfunction

endpackage

FILE: rtl/riff_signature_carver.sv
// ----------------------------------------------------------------------------
// riff_signature_carver
// Carves RIFF files out of a byte stream by signature and length field.
// ----------------------------------------------------------------------------
// An accepted word waits in the input register; its result then goes to the result register.
// Throughput: one byte per cycle while in_stall is low; a completed signature puts out four words
// from the output register and holds the input stage while its signature words are pending.
// Bytes that produce no word never wait on the output side.
// Reset (arst_n low, asynchronous): pipeline empty, scanning, file count zero.
`include "riff_signature_carver_macros.svh"

module riff_signature_carver import rsc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        new_stream,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  out_byte,
	output logic [15:0] file_number,
	output logic        first_of_file,
	output logic        last_of_file,
	output logic        aborted
);

	// Input register: one word waits here while the step logic looks at it.
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       fresh_s1;

	// Carver state, updated once per word leaving the input register.
	carve_state_t state_q;
	carve_state_t state_nxt;
	carve_res_t   res;

	// Result register. burst_left_q counts signature words still to follow
	// the one that is shown.
	logic        out_valid_q;
	logic [7:0]  out_byte_q;
	logic [15:0] file_number_q;
	logic        first_q;
	logic        last_q;
	logic        aborted_q;
	logic [1:0]  burst_left_q;

	logic can_load;
	logic s1_go;

	rsc_step u_step (
		.cur        (state_q),
		.data_byte  (byte_s1),
		.new_stream (fresh_s1),
		.nxt        (state_nxt),
		.res        (res)
	);

	// The result register takes a new word when it is empty, or when its word
	// leaves this cycle and no signature words are still pending.
	assign can_load = !out_valid_q || (!out_stall && burst_left_q == 2'd0);

	// A byte that yields no word moves on regardless of the output side.
	assign s1_go    = valid_s1 && (!res.valid || can_load);
	assign in_stall = valid_s1 && !s1_go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall) begin
			byte_s1  <= data_byte;
			fresh_s1 <= new_stream;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (s1_go) begin
			state_q <= state_nxt;
		end
	end

	// Control half of the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			burst_left_q <= 2'd0;
		end else if (s1_go && res.valid) begin
			out_valid_q  <= 1'b1;
			burst_left_q <= res.sig_burst ? 2'd3 : 2'd0;
		end else if (out_valid_q && !out_stall) begin
			if (burst_left_q != 2'd0) begin
				burst_left_q <= burst_left_q - 2'd1;
			end else begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload half. During a signature burst the next byte comes from the
	// table; the file number stays as loaded with the R.
	always_ff @(posedge clk) begin
		if (s1_go && res.valid) begin
			out_byte_q    <= res.data;
			file_number_q <= res.number;
			first_q       <= res.sig_burst;
			last_q        <= res.last;
			aborted_q     <= res.aborted;
		end else if (out_valid_q && !out_stall && burst_left_q != 2'd0) begin
			out_byte_q <= sig_byte(2'(3'd4 - {1'b0, burst_left_q}));
			first_q    <= 1'b0;
			last_q     <= 1'b0;
			aborted_q  <= 1'b0;
		end
	end

	assign out_valid     = out_valid_q;
	assign out_byte      = out_byte_q;
	assign file_number   = file_number_q;
	assign first_of_file = first_q;
	assign last_of_file  = last_q;
	assign aborted       = aborted_q;

	// Pending signature words imply a word on show that is no abort.
	`RSC_ASSERT_IMP(a_burst_shown, burst_left_q != 2'd0, out_valid_q && !aborted_q, "burst without word")
	// An abort word carries a zero byte and no file marks.
	`RSC_ASSERT_IMP(a_abort_clean, out_valid_q && aborted_q, out_byte_q == 8'd0 && !first_q && !last_q, "bad abort")
	// The R of a signature is followed at once by the I.
	`RSC_ASSERT_NXT(a_sig_follow, out_valid_q && !out_stall && first_q, out_valid_q && out_byte_q == SIG_I && burst_left_q == 2'd2, "signature broken")

endmodule

FILE: rtl/rsc_step.sv
// ----------------------------------------------------------------------------
// rsc_step
// Next-state and result logic for one input byte of the carver.
// ----------------------------------------------------------------------------
module rsc_step import rsc_pkg::*; (
	input  carve_state_t cur,
	input  logic [7:0]   data_byte,
	input  logic         new_stream,
	output carve_state_t nxt,
	output carve_res_t   res
);

	carve_state_t eff;
	logic [31:0]  acc;
	logic [31:0]  left_dec;
	logic [FILE_COUNT_BITS-1:0] count_inc;

	always_comb begin
		eff       = cur;
		res       = '0;
		acc       = cur.length_acc;
		left_dec  = cur.bytes_left - 32'd1;
		count_inc = cur.file_count + FILE_COUNT_BITS'(1);

		// A new source cuts any file in progress and restarts everything.
		if (new_stream) begin
			if (cur.phase == PH_LEN || cur.phase == PH_BODY) begin
				res.valid   = 1'b1;
				res.number  = 16'(cur.file_count);
				res.aborted = 1'b1;
			end
			eff = '0;
		end

		nxt = eff;
		acc = eff.length_acc;
		acc[{eff.length_pos, 3'b000} +: 8] = data_byte;

		unique case (eff.phase)
			PH_LEN: begin
				nxt.length_acc = acc;
				nxt.length_pos = eff.length_pos + 2'd1;
				res.valid      = 1'b1;
				res.data       = data_byte;
				res.number     = 16'(eff.file_count);
				if (eff.length_pos == 2'd3) begin
					nxt.bytes_left = acc;
					if (acc == 32'd0) begin
						res.last  = 1'b1;
						nxt.phase = PH_SCAN;
					end else begin
						nxt.phase = PH_BODY;
					end
				end
			end
			PH_BODY: begin
				nxt.bytes_left = left_dec;
				res.valid      = 1'b1;
				res.data       = data_byte;
				res.number     = 16'(eff.file_count);
				if (left_dec == 32'd0) begin
					res.last  = 1'b1;
					nxt.phase = PH_SCAN;
				end
			end
			default: begin
				// Scanning; the unused phase code also lands here.
				nxt.phase = PH_SCAN;
				if (data_byte == sig_byte(eff.match_pos)) begin
					if (eff.match_pos == 2'd3) begin
						nxt.match_pos  = 2'd0;
						nxt.file_count = count_inc;
						nxt.phase      = PH_LEN;
						nxt.length_pos = 2'd0;
						nxt.length_acc = 32'd0;
						nxt.bytes_left = 32'd0;
						res.valid      = 1'b1;
						res.sig_burst  = 1'b1;
						res.data       = SIG_R;
						res.number     = 16'(count_inc);
					end else begin
						nxt.match_pos = eff.match_pos + 2'd1;
					end
				end else begin
					nxt.match_pos = (data_byte == SIG_R) ? 2'd1 : 2'd0;
				end
			end
		endcase
	end

endmodule
